// ----- rtl/core/plt_pkg.sv -----
// Shared types, codes and defaults for the positional list table.
package plt_pkg;

    // Default list size and entry width
    localparam int PLT_DEPTH = 16;
    localparam int PLT_WIDTH = 32;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Request word
    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  position;
        logic [31:0] data_in;
    } req_word_t;

    // Response word
    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } rsp_word_t;

    // Finished result handed from the sequencer to the output stage
    typedef struct packed {
        logic      valid;
        rsp_word_t word;
    } res_t;

endpackage

// ----- rtl/core/plt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module plt_ram #(
    parameter int WIDTH = plt_pkg::PLT_WIDTH,
    parameter int DEPTH = plt_pkg::PLT_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and register the read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/plt_ctrl.sv -----
// Command sequencer: range checks, entry count and one-entry-at-a-time shifting.
module plt_ctrl #(
    parameter int DEPTH = plt_pkg::PLT_DEPTH,
    parameter int WIDTH = plt_pkg::PLT_WIDTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  plt_pkg::req_word_t       req,
    input  logic                     out_free,
    output plt_pkg::res_t            res,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [WIDTH-1:0]         ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [WIDTH-1:0]         ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        IDLE,
        SHIFT_RD,
        SHIFT_WR,
        PUT,
        DROP,
        FETCH,
        FINISH
    } state_t;

    state_t           state_reg,  state_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [CW-1:0]    idx_reg,    idx_next;
    logic [PW-1:0]    pos_reg,    pos_next;
    logic [1:0]       cmd_reg,    cmd_next;
    logic [1:0]       status_reg, status_next;
    logic [WIDTH-1:0] data_reg,   data_next;
    logic [WIDTH-1:0] rd_reg,     rd_next;

    logic [PW-1:0]    pos_in;
    logic [PW-1:0]    count_ext;
    logic [63:0]      din_wide;
    logic [63:0]      rd_wide;
    logic [CW-1:0]    src;

    assign pos_in    = PW'(req.position);
    assign count_ext = PW'(count_reg);
    assign din_wide  = 64'(req.data_in);
    assign rd_wide   = 64'(rd_reg);

    // Source cell of the current move: below for insert, above for remove
    assign src = (cmd_reg == plt_pkg::CMD_INSERT) ? idx_reg - CW'(1) : idx_reg + CW'(1);

    assign req_stall = (state_reg != IDLE);

    // Present the finished word
    always_comb
    begin
        res.valid            = (state_reg == FINISH);
        res.word.data_out    = rd_wide[31:0];
        res.word.status      = status_reg;
        res.word.entry_count = 5'(count_reg);
    end

    // Sequence one command
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        data_next   = data_reg;
        rd_next     = rd_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;

        unique case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = req.cmd;
                    pos_next    = pos_in;
                    data_next   = din_wide[WIDTH-1:0];
                    rd_next     = '0;
                    status_next = plt_pkg::ST_OK;
                    idx_next    = count_reg;
                    unique case (req.cmd)
                        plt_pkg::CMD_INSERT:
                        begin
                            priority if (pos_in > count_ext)
                            begin
                                status_next = plt_pkg::ST_RANGE;
                                state_next  = FINISH;
                            end
                            else if (count_reg == FULL_COUNT)
                            begin
                                status_next = plt_pkg::ST_FULL;
                                state_next  = FINISH;
                            end
                            else if (count_ext > pos_in)
                            begin
                                state_next = SHIFT_RD;
                            end
                            else
                            begin
                                state_next = PUT;
                            end
                        end
                        plt_pkg::CMD_REMOVE:
                        begin
                            idx_next = pos_in[CW-1:0];
                            priority if (pos_in >= count_ext)
                            begin
                                status_next = plt_pkg::ST_RANGE;
                                state_next  = FINISH;
                            end
                            else if (pos_in + PW'(1) < count_ext)
                            begin
                                state_next = SHIFT_RD;
                            end
                            else
                            begin
                                state_next = DROP;
                            end
                        end
                        plt_pkg::CMD_WRITE:
                        begin
                            if (pos_in >= count_ext)
                            begin
                                status_next = plt_pkg::ST_RANGE;
                                state_next  = FINISH;
                            end
                            else
                            begin
                                state_next = PUT;
                            end
                        end
                        plt_pkg::CMD_READ:
                        begin
                            ram_raddr = pos_in[AW-1:0];
                            if (pos_in >= count_ext)
                            begin
                                status_next = plt_pkg::ST_RANGE;
                                state_next  = FINISH;
                            end
                            else
                            begin
                                state_next = FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = FINISH;
                        end
                    endcase
                end
            end
            SHIFT_RD:
            begin
                // Fetch the neighbor that moves into the current cell
                ram_raddr  = src[AW-1:0];
                state_next = SHIFT_WR;
            end
            SHIFT_WR:
            begin
                // Move one entry and advance the cell index
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = src;
                if (cmd_reg == plt_pkg::CMD_INSERT)
                begin
                    state_next = (PW'(src) > pos_reg) ? SHIFT_RD : PUT;
                end
                else
                begin
                    state_next = (PW'(src) + PW'(1) < count_ext) ? SHIFT_RD : DROP;
                end
            end
            PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[AW-1:0];
                ram_wdata = data_reg;
                if (cmd_reg == plt_pkg::CMD_INSERT)
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = FINISH;
            end
            DROP:
            begin
                count_next = count_reg - CW'(1);
                state_next = FINISH;
            end
            FETCH:
            begin
                rd_next    = ram_rdata;
                state_next = FINISH;
            end
            FINISH:
            begin
                // Hold until the output stage takes the word
                if (out_free)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold state, count and command context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        rd_reg     <= rd_next;
    end

endmodule

// ----- rtl/core/positional_list_table_unit.sv -----
// Top level of the positional list table: sequencer, entry RAM and output register.
//
// A bounded ordered list of up to DEPTH entries addressed by position, with insert,
// remove, overwrite and read commands; every command returns one word with status
// and the entry count after the command. One command is in work at a time and
// req_stall stays high until its result word has moved into the output register.
// A rejected command goes straight to FINISH, an overwrite through PUT and a read
// through FETCH. An insert at position p with n entries moves n-p entries and a
// remove n-p-1, each with one read (SHIFT_RD) and one write (SHIFT_WR) on the
// single entry RAM; an insert then writes its entry in PUT, a remove lowers the
// count in DROP. The result sits in an output register, so a new command is taken
// while the previous result still waits downstream; its own result then holds the
// sequencer until that word is taken. Entries are not cleared at reset; only
// written cells are ever read.
module positional_list_table_unit #(
    parameter int DEPTH = plt_pkg::PLT_DEPTH,
    parameter int WIDTH = plt_pkg::PLT_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  plt_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output plt_pkg::rsp_word_t rsp
);

    localparam int AW = $clog2(DEPTH);

    plt_pkg::res_t      res;
    logic               out_free;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WIDTH-1:0]   ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [WIDTH-1:0]   ram_rdata;

    logic               rsp_valid_reg, rsp_valid_next;
    plt_pkg::rsp_word_t rsp_reg;

    plt_ctrl #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .out_free  (out_free),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    plt_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register is free when empty or being drained this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Load a finished word, drop a taken one
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res.valid && out_free)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && out_free)
        begin
            rsp_reg <= res.word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
